@@ rtl/positional_list_engine_assert.svh @@
// Assertion macros used by the datapath RTL of the list engine.
// PLE_ASSERT checks a property on every clock; PLE_NEVER checks that a condition never holds.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define PLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PLE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define PLE_ASSERT(lbl, prop)
`define PLE_NEVER(lbl, cond)
`endif
`endif

@@ rtl/ple_pkg.sv @@
`default_nettype none
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int DataW    = 32;
  localparam int ReqW     = 3;
  localparam int PosW     = 6;
  localparam int StatW    = 2;
  localparam int CountW   = 6;
  localparam int CntW     = ($clog2(CAPACITY + 1) > CountW) ? $clog2(CAPACITY + 1) : CountW;
  localparam int IdxW     = $clog2(CAPACITY);

  typedef enum logic [ReqW-1:0] {
    ReqInsFront = 3'd0,
    ReqInsBack  = 3'd1,
    ReqInsAt    = 3'd2,
    ReqDelFront = 3'd3,
    ReqDelBack  = 3'd4,
    ReqDelAt    = 3'd5,
    ReqDump     = 3'd6
  } req_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StBadPos = 2'd1,
    StFull   = 2'd2,
    StEmpty  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic take;   // capture the request
    logic exec;   // run the request, load its first result
    logic step;   // load the next dump result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic dump_multi;  // captured request is a dump with more than one entry
    logic dump_final;  // dump index points at the final entry
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/ple_ctrl.sv @@
`default_nettype none
module ple_ctrl import ple_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.take = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == S_EXEC) && sts_i.out_free;
    cmd_o.step = (state_q == S_DUMP) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) state_d = sts_i.dump_multi ? S_DUMP : S_IDLE;
      end
      S_DUMP: begin
        if (sts_i.out_free && sts_i.dump_final) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ple_datapath.sv @@
`default_nettype none
`include "positional_list_engine_assert.svh"
module ple_datapath import ple_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [ReqW-1:0]     req_type_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic [PosW-1:0]     position_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [StatW-1:0]         status_o,
  output logic signed [DataW-1:0]  item_value_o,
  output logic [CountW-1:0]        count_o,
  output logic                     last_o
);

  localparam int PW = CntW + 1;

  // captured request
  logic [ReqW-1:0]  req_q;
  logic [DataW-1:0] val_q;
  logic [PosW-1:0]  pos_q;

  // list state
  logic [DataW-1:0] store_q [CAPACITY];
  logic [DataW-1:0] store_d [CAPACITY];
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  // output register
  logic             ovld_q, ovld_d;
  logic [StatW-1:0] ost_q;
  logic [DataW-1:0] oval_q;
  logic [CntW-1:0]  ocnt_q;
  logic             olast_q;

  logic             load;
  logic [StatW-1:0] st_w;
  logic [DataW-1:0] oval_w;
  logic             olast_w;
  logic             do_ins, do_del;
  logic [CntW-1:0]  ins_idx, del_idx;
  logic [PosW-1:0]  pos_m1;
  logic [PW-1:0]    pos_x, cnt_x;
  logic             full, empty;

  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign pos_m1  = pos_q - PosW'(1);
  assign pos_x   = PW'(pos_q);
  assign cnt_x   = PW'(count_q);

  // decode of the captured request
  always_comb begin
    st_w    = StOk;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_idx = '0;
    del_idx = '0;
    unique case (req_q)
      ReqInsFront, ReqInsBack: begin
        ins_idx = (req_q == ReqInsFront) ? '0 : count_q;
        if (full) st_w = StFull;
        else      do_ins = 1'b1;
      end
      ReqInsAt: begin
        ins_idx = CntW'(pos_m1);
        if (pos_q == '0 || pos_x > cnt_x + PW'(1)) st_w = StBadPos;
        else if (full)                             st_w = StFull;
        else                                       do_ins = 1'b1;
      end
      ReqDelFront, ReqDelBack: begin
        del_idx = (req_q == ReqDelFront) ? '0 : count_q - CntW'(1);
        if (empty) st_w = StEmpty;
        else       do_del = 1'b1;
      end
      ReqDelAt: begin
        del_idx = CntW'(pos_m1);
        if (pos_q == '0 || pos_x > cnt_x) st_w = StBadPos;
        else                              do_del = 1'b1;
      end
      ReqDump: begin
        if (empty) st_w = StEmpty;
      end
      default: st_w = StOk;
    endcase
  end

  // one cell per entry; each looks only at its own entry and its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] up_w, dn_w;
    if (g == 0) begin : g_first
      assign up_w = store_q[g];
    end else begin : g_up
      assign up_w = store_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_lastc
      assign dn_w = store_q[g];
    end else begin : g_dn
      assign dn_w = store_q[g+1];
    end
    always_comb begin
      store_d[g] = store_q[g];
      if (cmd_i.exec && do_ins) begin
        if (CntW'(g) == ins_idx)     store_d[g] = val_q;
        else if (CntW'(g) > ins_idx) store_d[g] = up_w;
      end else if (cmd_i.exec && do_del) begin
        if (CntW'(g) >= del_idx && CntW'(g + 1) < count_q) store_d[g] = dn_w;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.exec && do_ins) count_d = count_q + CntW'(1);
    if (cmd_i.exec && do_del) count_d = count_q - CntW'(1);
  end

  // result selection
  always_comb begin
    oval_w  = '0;
    olast_w = 1'b1;
    idx_d   = idx_q;
    if (cmd_i.step) begin
      oval_w  = store_q[idx_q];
      olast_w = sts_o.dump_final;
      idx_d   = idx_q + IdxW'(1);
    end else if (cmd_i.exec && req_q == ReqDump && !empty) begin
      oval_w  = store_q[0];
      olast_w = (count_q == CntW'(1));
      idx_d   = IdxW'(1);
    end
  end

  assign load = cmd_i.exec || cmd_i.step;

  always_comb begin
    sts_o.out_free   = !ovld_q || !out_stall_i;
    sts_o.dump_multi = (req_q == ReqDump) && (count_q > CntW'(1));
    sts_o.dump_final = (CntW'(idx_q) + CntW'(1) == count_q);
  end

  always_comb begin
    ovld_d = ovld_q;
    if (load)             ovld_d = 1'b1;
    else if (!out_stall_i) ovld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= req_type_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (load) begin
      ost_q   <= cmd_i.step ? StOk : st_w;
      oval_q  <= oval_w;
      ocnt_q  <= count_d;
      olast_q <= olast_w;
    end
    idx_q <= idx_d;
    for (int i = 0; i < CAPACITY; i++) begin
      store_q[i] <= store_d[i];
    end
  end

  assign out_valid_o  = ovld_q;
  assign status_o     = ost_q;
  assign item_value_o = oval_q;
  assign count_o      = ocnt_q[CountW-1:0];
  assign last_o       = olast_q;

  `PLE_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY))
  `PLE_NEVER(a_no_overwrite, ovld_q && out_stall_i && load)
  `PLE_ASSERT(a_ins_count, (cmd_i.exec && do_ins) |=> (count_q == $past(count_q) + CntW'(1)))
  `PLE_NEVER(a_exec_and_step, cmd_i.exec && cmd_i.step)

endmodule
`default_nettype wire

@@ rtl/positional_list_engine.sv @@
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_stall_o  req_type_i, value_i, position_i
// result    out        out_valid_o / out_stall_i status_o, item_value_o, count_o, last_o
//
// Each request is captured, then executed once the result register is free.
// Inserts/deletes shift entries from the target on at once via neighbor cells on execute.
// A dump of N > 0 entries gives N results: one at execute, then one per unstalled cycle.
// A stalled result register holds execution; a new request is captured while a result waits.
// Reset clears the count and the result valid; stored entries need no clearing.
`default_nettype none
module positional_list_engine import ple_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [ReqW-1:0]         req_type_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic [PosW-1:0]         position_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [StatW-1:0]             status_o,
  output logic signed [DataW-1:0]      item_value_o,
  output logic [CountW-1:0]            count_o,
  output logic                         last_o
);

  cmd_t cmd;
  sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .count_o      (count_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
